/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms, sampled on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/dsl_pkg.sv */
// ----------------------------------------------------------------------------
// dsl_pkg
// types, codes and character classes for the dollar-escape string lexer
// ----------------------------------------------------------------------------
package dsl_pkg;

    // result kinds
    typedef enum logic [2:0] {
        K_TEXT    = 3'd0,
        K_NAME    = 3'd1,
        K_NAMEEND = 3'd2,
        K_FINISH  = 3'd3,
        K_BADCR   = 3'd4,
        K_BADESC  = 3'd5
    } kind_t;

    // stop causes for a finished string
    localparam logic [1:0] CAUSE_NUL  = 2'd0;
    localparam logic [1:0] CAUSE_EOL  = 2'd1;
    localparam logic [1:0] CAUSE_PATH = 2'd2;

    // characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_BAR    = 8'h7c;
    localparam logic [7:0] CH_RBRACE = 8'h7d;

    // queue depth for results
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // one result transaction
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [1:0]  stop_cause;
        logic        last;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic is_name_ch(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic logic is_brace_name_ch(input logic [7:0] c);
        return is_name_ch(c) || c == CH_DOT;
    endfunction

    function automatic logic is_text_ch(input logic [7:0] c);
        return c != CH_NUL && c != CH_LF && c != CH_CR && c != CH_SPACE &&
               c != CH_DOLLAR && c != CH_COLON && c != CH_BAR;
    endfunction

    function automatic result_t mk_result(input kind_t k, input logic [7:0] v,
                                          input logic [1:0] cause);
        result_t r;
        r.kind       = k;
        r.value      = v;
        r.stop_cause = cause;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

/* hdl/dsl_if.sv */
// ----------------------------------------------------------------------------
// dsl_if
// valid/ready channels for input bytes and result tokens
// ----------------------------------------------------------------------------
interface dsl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface dsl_token_if;
    import dsl_pkg::*;

    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] value;
    logic [1:0] stop_cause;
    logic       last;

    modport source (output valid, output kind, output value, output stop_cause,
                    output last, input ready);
    modport sink   (input valid, input kind, input value, input stop_cause,
                    input last, output ready);
endinterface

/* hdl/dsl_lexer_fsm.sv */
// ----------------------------------------------------------------------------
// dsl_lexer_fsm
// phase register and per-byte decode into up to two results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsl_lexer_fsm (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      ch,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    output dsl_pkg::push_t  push
);
    import dsl_pkg::*;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_DOLLAR     = 4'd1,
        PH_CR         = 4'd2,
        PH_DOLLAR_CR  = 4'd3,
        PH_NAME       = 4'd4,
        PH_BRACE_OPEN = 4'd5,
        PH_BRACE_NAME = 4'd6,
        PH_SKIP_SP    = 4'd7,
        PH_DISCARD    = 4'd8
    } phase_t;

    typedef struct packed {
        logic    emit;
        result_t res;
        phase_t  ph;
    } plain_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   path_mode_reg;
    plain_t pl;
    phase_t end_ph;

    // byte in plain-text position, at most one result
    function automatic plain_t plain_byte(input logic [7:0] c, input logic pm);
        plain_t p;
        p.emit = 1'b0;
        p.res  = mk_result(K_TEXT, c, CAUSE_NUL);
        p.ph   = PH_START;
        if (c == CH_NUL) begin
            p.emit = 1'b1;
            p.res  = mk_result(K_FINISH, CH_NUL, CAUSE_NUL);
        end else if (is_text_ch(c)) begin
            p.emit = 1'b1;
        end else if (c == CH_DOLLAR) begin
            p.ph = PH_DOLLAR;
        end else if (c == CH_CR) begin
            p.ph = PH_CR;
        end else if (pm) begin
            p.emit = 1'b1;
            p.res  = mk_result(K_FINISH, CH_NUL, CAUSE_PATH);
            p.ph   = PH_DISCARD;
        end else if (c == CH_LF) begin
            p.emit = 1'b1;
            p.res  = mk_result(K_FINISH, CH_NUL, CAUSE_EOL);
            p.ph   = PH_DISCARD;
        end else begin
            p.emit = 1'b1;
        end
        return p;
    endfunction

    // decode of the current byte
    always_comb
    begin
        pl          = plain_byte(ch, path_mode_reg);
        end_ph      = (ch == CH_NUL) ? PH_START : PH_DISCARD;
        phase_next  = phase_reg;
        push.count  = 2'd0;
        push.first  = mk_result(K_TEXT, ch, CAUSE_NUL);
        push.second = pl.res;
        case (phase_reg)
            PH_DOLLAR:
            begin
                if (is_name_ch(ch)) begin
                    push.count = 2'd1;
                    push.first = mk_result(K_NAME, ch, CAUSE_NUL);
                    phase_next = PH_NAME;
                end else if (ch == CH_LF) begin
                    phase_next = PH_SKIP_SP;
                end else if (ch == CH_CR) begin
                    phase_next = PH_DOLLAR_CR;
                end else if (ch == CH_SPACE || ch == CH_DOLLAR || ch == CH_COLON) begin
                    push.count = 2'd1;
                    phase_next = PH_START;
                end else if (ch == CH_LBRACE) begin
                    phase_next = PH_BRACE_OPEN;
                end else begin
                    push.count = 2'd1;
                    push.first = mk_result(K_BADESC, CH_NUL, CAUSE_NUL);
                    phase_next = end_ph;
                end
            end
            PH_CR:
            begin
                push.count = 2'd1;
                if (ch == CH_LF) begin
                    push.first = mk_result(K_FINISH, CH_NUL, CAUSE_EOL);
                end else begin
                    push.first = mk_result(K_BADCR, CH_NUL, CAUSE_NUL);
                end
                phase_next = end_ph;
            end
            PH_DOLLAR_CR:
            begin
                if (ch == CH_LF) begin
                    phase_next = PH_SKIP_SP;
                end else begin
                    push.count = 2'd1;
                    push.first = mk_result(K_BADESC, CH_NUL, CAUSE_NUL);
                    phase_next = end_ph;
                end
            end
            PH_NAME:
            begin
                if (is_name_ch(ch)) begin
                    push.count = 2'd1;
                    push.first = mk_result(K_NAME, ch, CAUSE_NUL);
                end else begin
                    // name end mark, then the byte as plain text
                    push.count = pl.emit ? 2'd2 : 2'd1;
                    push.first = mk_result(K_NAMEEND, CH_NUL, CAUSE_NUL);
                    phase_next = (pl.ph == PH_DISCARD) ? end_ph : pl.ph;
                end
            end
            PH_BRACE_OPEN:
            begin
                push.count = 2'd1;
                if (is_brace_name_ch(ch)) begin
                    push.first = mk_result(K_NAME, ch, CAUSE_NUL);
                    phase_next = PH_BRACE_NAME;
                end else begin
                    push.first = mk_result(K_BADESC, CH_NUL, CAUSE_NUL);
                    phase_next = end_ph;
                end
            end
            PH_BRACE_NAME:
            begin
                push.count = 2'd1;
                if (is_brace_name_ch(ch)) begin
                    push.first = mk_result(K_NAME, ch, CAUSE_NUL);
                end else if (ch == CH_RBRACE) begin
                    push.first = mk_result(K_NAMEEND, CH_NUL, CAUSE_NUL);
                    phase_next = PH_START;
                end else begin
                    push.first = mk_result(K_BADESC, CH_NUL, CAUSE_NUL);
                    phase_next = end_ph;
                end
            end
            PH_SKIP_SP:
            begin
                if (ch != CH_SPACE) begin
                    push.count = {1'b0, pl.emit};
                    push.first = pl.res;
                    phase_next = (pl.ph == PH_DISCARD) ? end_ph : pl.ph;
                end
            end
            PH_DISCARD:
            begin
                if (ch == CH_NUL) begin
                    phase_next = PH_START;
                end
            end
            default:
            begin
                push.count = {1'b0, pl.emit};
                push.first = pl.res;
                phase_next = (pl.ph == PH_DISCARD) ? end_ph : pl.ph;
            end
        endcase
        // mark the final result of this byte
        push.first.last  = (push.count == 2'd1);
        push.second.last = 1'b1;
        if (!fire) begin
            push.count = 2'd0;
        end
    end

    // phase and mode registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= PH_START;
            path_mode_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg <= phase_next;
            end
            if (cfg_wr_en) begin
                path_mode_reg <= cfg_wr_data;
            end
        end
    end

    // two results only come from a name ended by a plain byte
    `ASSERT_IMPLIES(a_pair_after_name, push.count == 2'd2, phase_reg == PH_NAME, "stray pair")
    // discarded bytes give nothing
    `ASSERT_IMPLIES(a_discard_silent, phase_reg == PH_DISCARD, push.count == 2'd0, "discarded")

endmodule

/* hdl/dsl_result_fifo.sv */
// ----------------------------------------------------------------------------
// dsl_result_fifo
// small shifting queue of result transactions, takes up to two per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsl_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  dsl_pkg::push_t    push,
    output logic              room,
    output logic              head_valid,
    input  logic              head_ready,
    output dsl_pkg::result_t  head
);
    import dsl_pkg::*;

    localparam logic [QCNT_W-1:0] ROOM_LIMIT = QCNT_W'(QDEPTH - 2);

    result_t             q_reg  [QDEPTH];
    result_t             q_next [QDEPTH];
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QCNT_W-1:0]   base;
    logic                pop;

    assign pop        = head_valid && head_ready;
    assign head_valid = (count_reg != '0);
    assign head       = q_reg[0];
    assign room       = (count_reg <= ROOM_LIMIT);

    // shift out on pop, append pushed results behind the survivors
    always_comb
    begin
        base = count_reg - QCNT_W'(pop);
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) begin
                q_next[i] = q_reg[i + 1];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push.count != 2'd0 && QCNT_W'(i) == base) begin
                q_next[i] = push.first;
            end
            if (push.count == 2'd2 && QCNT_W'(i) == base + QCNT_W'(1)) begin
                q_next[i] = push.second;
            end
        end
        count_next = base + QCNT_W'(push.count);
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "queue overflow")
    `ASSERT_IMPLIES(a_push_with_room, push.count != 2'd0, room, "push without room")

endmodule

/* hdl/dollar_escape_string_lexer_top.sv */
// ----------------------------------------------------------------------------
// dollar_escape_string_lexer_top
// tokenizes a byte stream into text, variable names, end marks and error marks
// ----------------------------------------------------------------------------
// results: each result is written into a registered queue and offered from its head
// throughput: one byte per cycle while the queue has room; a byte giving two
//   results queues both, and input is held off while the queue holds over two results
// reset: asynchronous, active low; returns to plain text at string start with
//   path mode off and the result queue empty
module dollar_escape_string_lexer_top (
    input  logic         clk,
    input  logic         rst_n,
    dsl_byte_if.sink     str,
    dsl_token_if.source  tok,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);
    import dsl_pkg::*;

    push_t   push;
    result_t head;
    logic    room;
    logic    fire;

    // byte transaction accepted while the queue has room for two results
    assign str.ready = room;
    assign fire      = str.valid && room;

    dsl_lexer_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .ch          (str.ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push)
    );

    dsl_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (tok.valid),
        .head_ready (tok.ready),
        .head       (head)
    );

    // result transaction fields
    assign tok.kind       = head.kind;
    assign tok.value      = head.value;
    assign tok.stop_cause = head.stop_cause;
    assign tok.last       = head.last;

endmodule
